/* sv/preemptive_lcfs_scheduler_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the preemptive LCFS scheduler
// Wraps concurrent checks so that synthesis sees empty bodies.
// ---------------------------------------------------------------------------
`ifndef PREEMPTIVE_LCFS_SCHEDULER_CORE_DEFINES_SVH
`define PREEMPTIVE_LCFS_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define PLCFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define PLCFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLCFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PLCFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/plcfs_pkg.sv */
// ---------------------------------------------------------------------------
// plcfs_pkg
// Shared types and codes of the preemptive LCFS scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package plcfs_pkg;

  // Input command codes
  localparam logic CMD_ARRIVAL  = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ACCEPTED  = 2'd0;
  localparam logic [1:0] KIND_REJECTED  = 2'd1;
  localparam logic [1:0] KIND_COMPLETED = 2'd2;
  localparam logic [1:0] KIND_EMPTY     = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [15:0] job_id;
    logic [31:0] job_duration;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] completed_job_id;
    logic        schedule_valid;
    logic [31:0] next_completion_time;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

/* sv/plcfs_ctrl.sv */
// ---------------------------------------------------------------------------
// plcfs_ctrl
// Sequencer: takes one item, commits it into the output register once the output
// register is free, and tracks the output handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plcfs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output plcfs_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Decode commands
  always_comb begin
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.commit  = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  end

  // Next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/plcfs_dp.sv */
// ---------------------------------------------------------------------------
// plcfs_dp
// Datapath: job stack memory, cached top entry, count, start time, and the
// result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plcfs_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plcfs_pkg::in_item_t                 in_item,
  input  plcfs_pkg::ctrl_cmd_t                cmd,
  output plcfs_pkg::out_item_t                out_item,
  output logic [$clog2(STACK_DEPTH + 1)-1:0]  count_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Entries below the top live in memory; the top entry is held in registers
  logic [15:0]          id_mem  [STACK_DEPTH];
  logic [31:0]          rem_mem [STACK_DEPTH];

  plcfs_pkg::in_item_t  item_r;
  logic [15:0]          rd_id_r;
  logic [31:0]          rd_rem_r;
  logic [15:0]          top_id_r;
  logic [31:0]          top_rem_r;
  plcfs_pkg::out_item_t out_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [31:0]          run_start_r;
  logic [31:0]          run_start_nxt;

  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        cnt_m2;
  logic                 is_arr;
  logic                 full;
  logic                 empty;
  logic [31:0]          elapsed;
  logic [31:0]          charged;
  logic [31:0]          addend;
  logic [31:0]          sum;
  logic                 push_below;
  logic                 load_top_new;
  logic                 load_top_mem;
  plcfs_pkg::out_item_t res;

  assign cnt_m1  = count_r - CW'(1);
  assign cnt_m2  = count_r - CW'(2);
  assign is_arr  = (item_r.cmd == plcfs_pkg::CMD_ARRIVAL);
  assign full    = (count_r == CW'(STACK_DEPTH));
  assign empty   = (count_r == '0);

  // Charge the preempted job, saturating at zero
  assign elapsed = item_r.current_time - run_start_r;
  assign charged = (top_rem_r > elapsed) ? (top_rem_r - elapsed) : 32'd0;

  // Completion time of the job that runs next
  assign addend  = is_arr ? item_r.job_duration : rd_rem_r;
  assign sum     = item_r.current_time + addend;

  // Work out the result and the next control state
  always_comb begin
    res           = '0;
    count_nxt     = count_r;
    run_start_nxt = run_start_r;
    push_below    = 1'b0;
    load_top_new  = 1'b0;
    load_top_mem  = 1'b0;
    if (is_arr) begin
      if (full) begin
        res.result_kind = plcfs_pkg::KIND_REJECTED;
      end else begin
        res.result_kind          = plcfs_pkg::KIND_ACCEPTED;
        res.schedule_valid       = 1'b1;
        res.next_completion_time = sum;
        count_nxt                = count_r + CW'(1);
        run_start_nxt            = item_r.current_time;
        push_below               = !empty;
        load_top_new             = 1'b1;
      end
    end else begin
      run_start_nxt = item_r.current_time;
      if (empty) begin
        res.result_kind = plcfs_pkg::KIND_EMPTY;
      end else begin
        res.result_kind      = plcfs_pkg::KIND_COMPLETED;
        res.completed_job_id = top_id_r;
        count_nxt            = cnt_m1;
        if (count_r != CW'(1)) begin
          res.schedule_valid       = 1'b1;
          res.next_completion_time = sum;
          load_top_mem             = 1'b1;
        end
      end
    end
  end

  // Capture the item and read the entry below the top; commit updates
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r   <= in_item;
      rd_id_r  <= id_mem[cnt_m2[AW-1:0]];
      rd_rem_r <= rem_mem[cnt_m2[AW-1:0]];
    end
    if (cmd.commit) begin
      out_r <= res;
      if (push_below) begin
        id_mem[cnt_m1[AW-1:0]]  <= top_id_r;
        rem_mem[cnt_m1[AW-1:0]] <= charged;
      end
      if (load_top_new) begin
        top_id_r  <= item_r.job_id;
        top_rem_r <= item_r.job_duration;
      end else if (load_top_mem) begin
        top_id_r  <= rd_id_r;
        top_rem_r <= rd_rem_r;
      end
    end
  end

  // Hold count and start time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      run_start_r <= '0;
    end else if (cmd.commit) begin
      count_r     <= count_nxt;
      run_start_r <= run_start_nxt;
    end
  end

  assign out_item = out_r;
  assign count_o  = count_r;

endmodule

/* sv/preemptive_lcfs_scheduler_core.sv */
// A result passes the capture step, then the commit into the output register,
// before it can be taken.
// A new item is taken only after the last one is committed (capture with stack
// read, then commit with one stack write); the commit waits while a finished result is stalled.
// Reset clears the job count and run start time; stack contents stay
// undefined and are only used below the count. No clearing pass is needed.
// ---------------------------------------------------------------------------
// preemptive_lcfs_scheduler_core
// Preemptive last-come-first-served scheduler with a bounded job stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "preemptive_lcfs_scheduler_core_defines.svh"

module preemptive_lcfs_scheduler_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  plcfs_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output plcfs_pkg::out_item_t out_item
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  plcfs_pkg::ctrl_cmd_t cmd;
  logic [CW-1:0]        count;

  plcfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  plcfs_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .out_item (out_item),
    .count_o  (count)
  );

  // Checks
  `PLCFS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accept did not block input")
  `PLCFS_ASSERT_NXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_valid, "commit without result")
  `PLCFS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count <= CW'(STACK_DEPTH), "stack count overflow")

endmodule
